// File: rtl/crc14_packet_framer_macros.svh
// Assertion macros used by the framer back end (cpf_back).
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef CRC14_PACKET_FRAMER_MACROS_SVH
`define CRC14_PACKET_FRAMER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CPF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define CPF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/cpf_pkg.sv
package cpf_pkg;

  // Largest packet in bytes: three header bytes, the payload and two CRC bytes.
  localparam int MAX_PACKET = 64;

  localparam int LEN_W = 6;
  localparam int CRC_W = 14;
  localparam int PAYLOAD_LIMIT_RAW = (MAX_PACKET - 5 < 0) ? 0 : MAX_PACKET - 5;
  localparam int PAYLOAD_LIMIT = (PAYLOAD_LIMIT_RAW > 63) ? 63 : PAYLOAD_LIMIT_RAW;

  localparam logic [CRC_W-1:0] CRC_INIT   = 14'h3fff;
  localparam logic [CRC_W-1:0] CRC_POLY   = 14'h22f0;
  localparam logic [CRC_W-1:0] CRC_XOROUT = 14'h3fff;
  localparam int CRC_BITS = 7;

  // Depth of the job queue between front and back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);

  // Item kinds on the input channel.
  typedef enum logic {
    KIND_HEADER = 1'b0,
    KIND_DATA   = 1'b1
  } kind_e;

  typedef struct packed {
    logic             kind;
    logic [7:0]       address;
    logic [7:0]       command;
    logic [LEN_W-1:0] payload_length;
    logic [7:0]       data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       last;
  } out_item_t;

  // One job for the back end: a header or a payload byte, plus whether the
  // trailer follows it.
  typedef struct packed {
    logic             is_hdr;
    logic [7:0]       first;
    logic [7:0]       command;
    logic [LEN_W-1:0] length;
    logic             close;
  } job_t;

  // Handshake between the queue and the back end.
  typedef struct packed {
    logic valid;
    job_t job;
  } queue_head_t;

  // Phases of the back-end byte sequencer.
  typedef enum logic [2:0] {
    PH_FIRST,
    PH_CMD,
    PH_LEN,
    PH_CRC_LO,
    PH_CRC_HI
  } phase_e;

  // Reflected CRC-14 update over the low seven bits of one byte.
  function automatic logic [CRC_W-1:0] crc_feed(logic [CRC_W-1:0] crc,
                                                logic [CRC_BITS-1:0] b);
    logic [CRC_W-1:0] c;
    c = crc ^ {{(CRC_W-CRC_BITS){1'b0}}, b};
    for (int k = 0; k < CRC_BITS; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// File: rtl/crc14_packet_framer.sv
// Byte-serial packet framer with a reflected CRC-14 trailer. A header transfer
// emits address, command and the clamped payload length (three output bytes,
// five when the length is zero); each payload transfer emits one byte, and the
// last one is followed by two 7-bit CRC bytes, the second flagged as last.
// Payload transfers with no open packet are dropped. The input side accepts one
// transfer per cycle while the four-entry job queue has room; the output side
// delivers one byte per cycle through its output register while a job is queued
// and the receiver is ready or the register is empty, so the sustained rate is
// set by the number of output bytes per packet. The CRC of one byte is computed
// combinationally in the back end.
module crc14_packet_framer (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  cpf_pkg::in_item_t  in_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output cpf_pkg::out_item_t out_o
);
  import cpf_pkg::*;

  logic        push;
  job_t        push_job;
  logic        queue_full;
  logic        pop;
  queue_head_t head;

  // Front end: accept, classify, track the open packet.
  cpf_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_i         (in_i),
    .push_o       (push),
    .push_job_o   (push_job),
    .queue_full_i (queue_full)
  );

  // Job queue between the two halves.
  cpf_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .full_o     (queue_full),
    .pop_i      (pop),
    .head_o     (head)
  );

  // Back end: byte sequencer, CRC and output register.
  cpf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

endmodule

// File: rtl/cpf_queue.sv
module cpf_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  cpf_pkg::job_t       push_job_i,
  output logic                full_o,
  input  logic                pop_i,
  output cpf_pkg::queue_head_t head_o
);
  import cpf_pkg::*;

  job_t              slots_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QPTR_W:0]   count_q, count_d;
  logic              do_pop;

  assign full_o     = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
  assign head_o.valid = (count_q != '0);
  assign head_o.job   = slots_q[rd_ptr_q];
  assign do_pop     = pop_i && head_o.valid;

  // Pointer and occupancy update.
  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && do_pop) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Slot storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= push_job_i;
    end
  end

endmodule

// File: rtl/cpf_front.sv
module cpf_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  cpf_pkg::in_item_t in_i,
  output logic              push_o,
  output cpf_pkg::job_t     push_job_o,
  input  logic              queue_full_i
);
  import cpf_pkg::*;

  logic             open_q, open_d;
  logic [LEN_W-1:0] left_q, left_d;
  logic [LEN_W-1:0] len_clamped;
  logic             accept;
  logic             is_hdr;

  assign in_ready_o  = !queue_full_i;
  assign accept      = in_valid_i && in_ready_o;
  assign is_hdr      = (in_i.kind == KIND_HEADER);
  assign len_clamped = (in_i.payload_length > LEN_W'(PAYLOAD_LIMIT)) ?
                       LEN_W'(PAYLOAD_LIMIT) : in_i.payload_length;

  // Classify the transfer and track the open packet.
  always_comb begin
    open_d             = open_q;
    left_d             = left_q;
    push_o             = 1'b0;
    push_job_o.is_hdr  = is_hdr;
    push_job_o.first   = is_hdr ? in_i.address : in_i.data_byte;
    push_job_o.command = in_i.command;
    push_job_o.length  = len_clamped;
    push_job_o.close   = is_hdr ? (len_clamped == '0) : (left_q <= LEN_W'(1));
    if (accept) begin
      if (is_hdr) begin
        push_o = 1'b1;
        left_d = len_clamped;
        open_d = (len_clamped != '0);
      end else if (open_q) begin
        // Stray data with no open packet is dropped.
        push_o = 1'b1;
        left_d = (left_q != '0) ? left_q - 1'b1 : left_q;
        open_d = (left_d != '0);
        if (left_d == '0) begin
          left_d = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= 1'b0;
      left_q <= '0;
    end else begin
      open_q <= open_d;
      left_q <= left_d;
    end
  end

endmodule

// File: rtl/cpf_back.sv
`include "crc14_packet_framer_macros.svh"

module cpf_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cpf_pkg::queue_head_t head_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output cpf_pkg::out_item_t   out_o
);
  import cpf_pkg::*;

  phase_e           phase_q, phase_d;
  logic [CRC_W-1:0] crc_q, crc_d;
  logic [CRC_W-1:0] crc_out;
  logic             out_valid_q, out_valid_d;
  out_item_t        out_q, out_d;
  logic             advance;
  logic             emit;
  job_t             job;

  assign job     = head_i.job;
  assign advance = !out_valid_q || out_ready_i;
  assign emit    = advance && head_i.valid;
  assign crc_out = crc_q ^ CRC_XOROUT;

  // Next phase of the byte sequencer.
  always_comb begin
    phase_d = phase_q;
    if (emit) begin
      case (phase_q)
        PH_FIRST: begin
          if (job.is_hdr) begin
            phase_d = PH_CMD;
          end else if (job.close) begin
            phase_d = PH_CRC_LO;
          end else begin
            phase_d = PH_FIRST;
          end
        end
        PH_CMD:    phase_d = PH_LEN;
        PH_LEN:    phase_d = job.close ? PH_CRC_LO : PH_FIRST;
        PH_CRC_LO: phase_d = PH_CRC_HI;
        PH_CRC_HI: phase_d = PH_FIRST;
        default:   phase_d = PH_FIRST;
      endcase
    end
  end

  // Byte selection, CRC update and queue pop.
  always_comb begin
    out_d       = out_q;
    crc_d       = crc_q;
    pop_o       = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    if (emit) begin
      out_valid_d  = 1'b1;
      out_d.last   = 1'b0;
      case (phase_q)
        PH_FIRST: begin
          out_d.tx_byte = job.first;
          crc_d = crc_feed(job.is_hdr ? CRC_INIT : crc_q, job.first[CRC_BITS-1:0]);
          pop_o = !job.is_hdr && !job.close;
        end
        PH_CMD: begin
          out_d.tx_byte = job.command;
          crc_d = crc_feed(crc_q, job.command[CRC_BITS-1:0]);
        end
        PH_LEN: begin
          out_d.tx_byte = {{(8-LEN_W){1'b0}}, job.length};
          crc_d = crc_feed(crc_q, CRC_BITS'(job.length));
          pop_o = !job.close;
        end
        PH_CRC_LO: begin
          out_d.tx_byte = {1'b0, crc_out[CRC_BITS-1:0]};
        end
        PH_CRC_HI: begin
          out_d.tx_byte = {1'b0, crc_out[CRC_W-1:CRC_BITS]};
          out_d.last    = 1'b1;
          crc_d         = CRC_INIT;
          pop_o         = 1'b1;
        end
        default: begin
          out_d.tx_byte = job.first;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_FIRST;
      crc_q       <= CRC_INIT;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      crc_q       <= crc_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output payload register needs no reset.
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // A job must stay at the queue head until its last byte has gone out.
  `CPF_ASSERT_NOW(a_head_held, phase_q != PH_FIRST, head_i.valid,
    "back end lost its job in mid-sequence")
  // The second CRC byte always carries the last flag.
  `CPF_ASSERT_NEXT(a_last_flag, emit && phase_q == PH_CRC_HI,
    out_valid_q && out_q.last, "trailer byte went out without the last flag")
  // While the closing byte is on offer the CRC has been rearmed.
  `CPF_ASSERT_NOW(a_crc_rearmed, out_valid_q && out_q.last, crc_q == CRC_INIT,
    "CRC not reset after packet trailer")

endmodule

// File: bench/tb.sv
module tb;
  import cpf_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 16;
  localparam int RANDOM_ITEMS   = 350;

  // Tracks the framer state and holds the bytes that the packets must produce.
  class frame_tracker;
    out_item_t   expected_bytes[$];
    logic [13:0] crc_reg;
    logic [5:0]  remaining;
    logic        open_pkt;
    int          errors;

    function new();
      crc_reg   = CRC_INIT;
      remaining = '0;
      open_pkt  = 1'b0;
      errors    = 0;
    endfunction

    // Reflected CRC-14, one bit at a time over the low seven bits of a byte.
    function automatic logic [13:0] crc14_step(logic [13:0] c, logic [7:0] b);
      logic fb;
      for (int i = 0; i < 7; i++) begin
        fb = c[0] ^ b[i];
        c  = c >> 1;
        if (fb) begin
          c = c ^ CRC_POLY;
        end
      end
      return c;
    endfunction

    function void push_byte(logic [7:0] b, logic lst);
      out_item_t o;
      o.tx_byte = b;
      o.last    = lst;
      expected_bytes.push_back(o);
    endfunction

    // Appends the two seven-bit CRC bytes and closes the packet.
    function void append_trailer();
      logic [13:0] fin;
      fin = crc_reg ^ CRC_XOROUT;
      push_byte({1'b0, fin[6:0]}, 1'b0);
      push_byte({1'b0, fin[13:7]}, 1'b1);
      crc_reg   = CRC_INIT;
      remaining = '0;
      open_pkt  = 1'b0;
    endfunction

    // Notes one accepted input transfer and works out the bytes it causes.
    function void absorb_item(in_item_t it);
      logic [5:0] len;
      if (it.kind == KIND_HEADER) begin
        len = it.payload_length;
        if (len > PAYLOAD_LIMIT) begin
          len = 6'(PAYLOAD_LIMIT);
        end
        crc_reg = crc14_step(CRC_INIT, it.address);
        crc_reg = crc14_step(crc_reg, it.command);
        crc_reg = crc14_step(crc_reg, {2'b00, len});
        push_byte(it.address, 1'b0);
        push_byte(it.command, 1'b0);
        push_byte({2'b00, len}, 1'b0);
        remaining = len;
        open_pkt  = 1'b1;
        if (len == 0) begin
          append_trailer();
        end
      end else if (open_pkt) begin
        crc_reg = crc14_step(crc_reg, it.data_byte);
        push_byte(it.data_byte, 1'b0);
        if (remaining > 0) begin
          remaining--;
        end
        if (remaining == 0) begin
          append_trailer();
        end
      end
    endfunction

    // Compares one accepted output transfer with the oldest expected byte.
    function void check_byte(out_item_t got);
      out_item_t exp_b;
      if (expected_bytes.size() == 0) begin
        $display("%0t: unexpected output byte %02h last %0b", $time, got.tx_byte, got.last);
        errors++;
        return;
      end
      exp_b = expected_bytes.pop_front();
      if (got.tx_byte !== exp_b.tx_byte) begin
        $display("%0t: tx_byte mismatch, expected %02h, got %02h",
                 $time, exp_b.tx_byte, got.tx_byte);
        errors++;
      end
      if (got.last !== exp_b.last) begin
        $display("%0t: last mismatch, expected %0b, got %0b", $time, exp_b.last, got.last);
        errors++;
      end
    endfunction

    function int pending();
      return expected_bytes.size();
    endfunction
  endclass

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_ready_o;
  in_item_t  in_i        = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_item_t out_o;

  frame_tracker tracker = new();
  int burst_left = 4;
  int idle_cycles = 0;
  int cyc = 0;
  int items_sent = 0;

  crc14_packet_framer uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_i        (in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

  always #1 clk_i = ~clk_i;

  // The receiver cycles through phases: always ready, random, sparse and mostly ready.
  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    case ((cyc >> 7) % 4)
      0: begin
        out_ready_i <= 1'b1;
      end
      1: begin
        out_ready_i <= ($urandom_range(0, 9) < 7);
      end
      2: begin
        out_ready_i <= (cyc % 5 == 0);
      end
      default: begin
        out_ready_i <= (cyc[3:2] != 2'b11);
      end
    endcase
  end

  // Observes both channels at each edge and guards against a stalled run.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        tracker.absorb_item(in_i);
      end
      if (out_valid_o && out_ready_i) begin
        tracker.check_byte(out_o);
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Presents one item, waits for its transfer, then applies the burst pacing.
  task automatic send_item(input in_item_t it);
    int gap;
    in_valid_i <= 1'b1;
    in_i       <= it;
    do @(posedge clk_i); while (!in_ready_o);
    burst_left--;
    if (burst_left <= 0) begin
      gap        = $urandom_range(0, 6);
      burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic send_header(input logic [7:0] addr, input logic [7:0] cmd,
                             input logic [5:0] len);
    in_item_t it;
    it                = in_item_t'($urandom);
    it.kind           = KIND_HEADER;
    it.address        = addr;
    it.command        = cmd;
    it.payload_length = len;
    send_item(it);
  endtask

  task automatic send_data(input logic [7:0] b);
    in_item_t it;
    it.address        = 8'($urandom);
    it.command        = 8'($urandom);
    it.payload_length = 6'($urandom);
    it.kind           = KIND_DATA;
    it.data_byte      = b;
    send_item(it);
  endtask

  initial begin
    int n_data;
    int len;
    int pick;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: empty packets at the field extremes, short packets,
    // stray payload, an overlong length and a header that abandons a packet.
    send_header(8'h00, 8'h00, 6'd0);
    send_header(8'hff, 8'hff, 6'd0);
    send_header(8'ha5, 8'h5a, 6'd1);
    send_data(8'h00);
    send_header(8'h3c, 8'hc3, 6'd2);
    send_data(8'hff);
    send_data(8'h80);
    send_data(8'h7f);
    send_header(8'h01, 8'h02, 6'd63);
    send_data(8'h11);
    send_data(8'h22);
    send_header(8'h80, 8'h7f, 6'd3);
    send_data(8'h55);
    send_data(8'haa);
    send_data(8'h01);
    send_data(8'hfe);
    send_header(8'h12, 8'h34, 6'd60);
    send_data(8'hc0);
    send_header(8'h56, 8'h78, 6'd1);
    send_data(8'h3f);

    // Random part: mostly complete packets with random content, some cut short
    // by a new header, some stray payload and some unstructured noise.
    while (items_sent < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(40, 63) : $urandom_range(0, 8);
        send_header(8'($urandom), 8'($urandom), 6'(len));
        n_data = (len > PAYLOAD_LIMIT) ? PAYLOAD_LIMIT : len;
        if (n_data > 0 && $urandom_range(0, 9) == 0) begin
          n_data = $urandom_range(0, n_data - 1);
        end
        items_sent += 1 + n_data;
        repeat (n_data) send_data(8'($urandom));
      end else if (pick < 90) begin
        // Only reaches the block as stray payload when the last packet was closed.
        send_data(8'($urandom));
        items_sent++;
      end else begin
        repeat ($urandom_range(1, 4)) begin
          send_item(in_item_t'($urandom));
          items_sent++;
        end
      end
    end
    in_valid_i <= 1'b0;

    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (tracker.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
